/* src/fcp_pkg.sv */
// ----------------------------------------------------------------------------
// fcp_pkg
// Shared widths, register indexes and the derived configuration bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package fcp_pkg;

  localparam int IN_BITS       = 32;  // time_ticks field
  localparam int TIME_BITS_DEF = 32;
  localparam int LEG_W         = 24;
  localparam int PER_W         = 25;  // 2 * leg
  localparam int FREQ_W        = 32;
  localparam int PH_W          = 48;  // phase accumulator, one turn = 2^48
  localparam int HALF_W        = 24;  // partial product split
  localparam int LIM_W         = 32;
  localparam int OUT_W         = 32;
  localparam int CFG_AW        = 2;
  localparam int CFG_DW        = 48;

  localparam logic [CFG_AW-1:0] REG_LEG   = 2'd0;
  localparam logic [CFG_AW-1:0] REG_FREQ  = 2'd1;
  localparam logic [CFG_AW-1:0] REG_CURV  = 2'd2;
  localparam logic [CFG_AW-1:0] REG_LIMIT = 2'd3;

  typedef struct packed {
    logic [LEG_W-1:0]  d;    // leg length, zero taken as one
    logic [PER_W-1:0]  per;  // period length 2*d
    logic [FREQ_W-1:0] f;    // start frequency word
    logic [PH_W-1:0]   c;    // curvature, two's complement
    logic [LIM_W-1:0]  lim;  // period limit, 0 = endless
    logic [PH_W-1:0]   p;    // phase of one leg
    logic [PH_W-1:0]   k;    // down leg slope f48 + 2*c*d
  } cfg_t;

endpackage

`default_nettype wire

/* src/fcp_if.sv */
// ----------------------------------------------------------------------------
// fcp_in_if / fcp_out_if
// Valid/ready channels for time words in and phase words out.
// ----------------------------------------------------------------------------
`default_nettype none

interface fcp_in_if;
  import fcp_pkg::*;
  logic               valid;
  logic               ready;
  logic [IN_BITS-1:0] time_ticks;
  modport source (output valid, output time_ticks, input ready);
  modport sink   (input valid, input time_ticks, output ready);
endinterface

interface fcp_out_if;
  import fcp_pkg::*;
  logic             valid;
  logic             ready;
  logic [OUT_W-1:0] phase_turns;
  logic             active;
  modport source (output valid, output phase_turns, output active, input ready);
  modport sink   (input valid, input phase_turns, input active, output ready);
endinterface

`default_nettype wire

/* src/fcp_cfg.sv */
// ----------------------------------------------------------------------------
// fcp_cfg
// Configuration registers and the pipelined leg constants P and K.
// ----------------------------------------------------------------------------
`default_nettype none

module fcp_cfg import fcp_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_wr_en,
  input  wire logic [CFG_AW-1:0] cfg_index,
  input  wire logic [CFG_DW-1:0] cfg_data,
  output cfg_t                   cfg
);

  logic [LEG_W-1:0]  leg;
  logic [FREQ_W-1:0] freq;
  logic [PH_W-1:0]   curv;
  logic [LIM_W-1:0]  limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      leg   <= LEG_W'(1);
      freq  <= '0;
      curv  <= '0;
      limit <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_LEG:   leg   <= cfg_data[LEG_W-1:0];
        REG_FREQ:  freq  <= cfg_data[FREQ_W-1:0];
        REG_CURV:  curv  <= cfg_data[PH_W-1:0];
        REG_LIMIT: limit <= cfg_data[LIM_W-1:0];
        default: ;
      endcase
    end
  end

  logic [LEG_W-1:0] d;
  assign d = (leg == '0) ? LEG_W'(1) : leg;

  // stage 1
  logic [PH_W-1:0]   dd;
  logic [FREQ_W-1:0] fd;
  logic [PH_W-1:0]   cld;
  logic [HALF_W-1:0] chd;
  // stage 2
  logic [PH_W-1:0]   cdd_a;
  logic [HALF_W-1:0] cdd_b, cdd_c;
  logic [PH_W-1:0]   cd;
  logic [FREQ_W-1:0] fd2;
  // stage 3
  logic [PH_W-1:0]   p, k;

  logic [PH_W-1:0]   fd_w, cld_w, chd_w, cb_w, cc_w, fd48;

  always_comb begin
    fd_w  = PH_W'(freq * d);
    cld_w = PH_W'(curv[HALF_W-1:0] * d);
    chd_w = PH_W'(curv[PH_W-1:HALF_W] * d);
    cb_w  = PH_W'(curv[PH_W-1:HALF_W] * dd[HALF_W-1:0]);
    cc_w  = PH_W'(curv[HALF_W-1:0] * dd[PH_W-1:HALF_W]);
    fd48  = {fd2, 16'b0};
  end

  // config must only change while idle, which this block does not enforce; these settle long before an item needs them
  always_ff @(posedge clk) begin
    dd    <= PH_W'(d * d);
    fd    <= fd_w[FREQ_W-1:0];
    cld   <= cld_w;
    chd   <= chd_w[HALF_W-1:0];
    cdd_a <= PH_W'(curv[HALF_W-1:0] * dd[HALF_W-1:0]);
    cdd_b <= cb_w[HALF_W-1:0];
    cdd_c <= cc_w[HALF_W-1:0];
    cd    <= cld + {chd, 24'b0};
    fd2   <= fd;
    p     <= fd48 + cdd_a + {HALF_W'(cdd_b + cdd_c), 24'b0};
    k     <= {freq, 16'b0} + {cd[PH_W-2:0], 1'b0};
  end

  always_comb begin
    cfg.d   = d;
    cfg.per = {d, 1'b0};
    cfg.f   = freq;
    cfg.c   = curv;
    cfg.lim = limit;
    cfg.p   = p;
    cfg.k   = k;
  end

endmodule

`default_nettype wire

/* src/fcp_div.sv */
// ----------------------------------------------------------------------------
// fcp_div
// Pipelined restoring divider: time / period, one quotient bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module fcp_div import fcp_pkg::*; #(
  parameter int QB = TIME_BITS_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             en,
  input  wire logic             in_vld,
  input  wire logic [QB-1:0]    n,
  input  wire logic [PER_W-1:0] per,
  output logic                  out_vld,
  output logic [QB-1:0]         q,
  output logic [PER_W-1:0]      r
);

  logic [QB-1:0]    n_s [0:QB];
  logic [QB-1:0]    q_s [0:QB];
  logic [PER_W-1:0] r_s [0:QB];
  logic             v_s [0:QB];

  always_ff @(posedge clk) begin
    if (rst) v_s[0] <= 1'b0;
    else if (en) v_s[0] <= in_vld;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n_s[0] <= n;
      q_s[0] <= '0;
      r_s[0] <= '0;
    end
  end

  for (genvar s = 0; s < QB; s++) begin : g_stage
    logic [PER_W:0]   t, tn;
    logic             ge;
    logic [QB-1:0]    qn;

    always_comb begin
      t  = {r_s[s], n_s[s][QB-1-s]};
      ge = (t >= {1'b0, per});
      tn = ge ? (t - {1'b0, per}) : t;
      qn = q_s[s];
      qn[QB-1-s] = ge;
    end

    always_ff @(posedge clk) begin
      if (rst) v_s[s+1] <= 1'b0;
      else if (en) v_s[s+1] <= v_s[s];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        n_s[s+1] <= n_s[s];
        q_s[s+1] <= qn;
        r_s[s+1] <= tn[PER_W-1:0];
      end
    end
  end

  assign out_vld = v_s[QB];
  assign q       = q_s[QB];
  assign r       = r_s[QB];

endmodule

`default_nettype wire

/* src/fcp_phase.sv */
// ----------------------------------------------------------------------------
// fcp_phase
// Leg select and phase polynomial, five stages ending in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module fcp_phase import fcp_pkg::*; #(
  parameter int QB = TIME_BITS_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             en,
  input  wire logic             in_vld,
  input  wire logic [QB-1:0]    idx,
  input  wire logic [PER_W-1:0] loc,
  input  cfg_t                  cfg,
  output logic                  out_vld,
  output logic [OUT_W-1:0]      phase,
  output logic                  act_out
);

  logic va, vb, vc, vd;

  // stage A
  logic [HALF_W-1:0] a_u;
  logic              a_up, a_act;
  logic [PH_W-1:0]   a_idx2;
  // stage B
  logic [PH_W-1:0]   b_uu, b_bpl, b_kl;
  logic [HALF_W-1:0] b_bph, b_bpx, b_kh;
  logic [FREQ_W-1:0] b_fu;
  logic              b_up, b_act;
  // stage C
  logic [PH_W-1:0]   c_base, c_ku, c_fu, c_ca;
  logic [HALF_W-1:0] c_cb, c_cc;
  logic              c_up, c_act;
  // stage D
  logic [PH_W-1:0]   d_base, d_ku, d_fu, d_cuu;
  logic              d_up, d_act;

  logic [PER_W-1:0]  loc_d;
  logic [PH_W-1:0]   bph_w, bpx_w, kh_w, fu_w, cb_w, cc_w, phi;

  always_comb begin
    loc_d = loc - {1'b0, cfg.d};
    bph_w = PH_W'(a_idx2[PH_W-1:HALF_W] * cfg.p[HALF_W-1:0]);
    bpx_w = PH_W'(a_idx2[HALF_W-1:0] * cfg.p[PH_W-1:HALF_W]);
    kh_w  = PH_W'(cfg.k[PH_W-1:HALF_W] * a_u);
    fu_w  = PH_W'(cfg.f * a_u);
    cb_w  = PH_W'(cfg.c[PH_W-1:HALF_W] * b_uu[HALF_W-1:0]);
    cc_w  = PH_W'(cfg.c[HALF_W-1:0] * b_uu[PH_W-1:HALF_W]);
    if (d_up) phi = d_base + d_fu + d_cuu;
    else      phi = d_base + cfg.p + d_ku - d_cuu;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0; vb <= 1'b0; vc <= 1'b0; vd <= 1'b0; out_vld <= 1'b0;
    end else if (en) begin
      va <= in_vld; vb <= va; vc <= vb; vd <= vc; out_vld <= vd;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_up   <= (loc < {1'b0, cfg.d});
      a_u    <= (loc < {1'b0, cfg.d}) ? loc[HALF_W-1:0] : loc_d[HALF_W-1:0];
      a_idx2 <= {{(PH_W-1-QB){1'b0}}, idx, 1'b0};
      a_act  <= (cfg.lim == '0) ||
                ({{(PH_W-QB){1'b0}}, idx} < {{(PH_W-LIM_W){1'b0}}, cfg.lim});

      b_uu   <= PH_W'(a_u * a_u);
      b_bpl  <= PH_W'(a_idx2[HALF_W-1:0] * cfg.p[HALF_W-1:0]);
      b_bph  <= bph_w[HALF_W-1:0];
      b_bpx  <= bpx_w[HALF_W-1:0];
      b_kl   <= PH_W'(cfg.k[HALF_W-1:0] * a_u);
      b_kh   <= kh_w[HALF_W-1:0];
      b_fu   <= fu_w[FREQ_W-1:0];
      b_up   <= a_up;
      b_act  <= a_act;

      c_base <= b_bpl + {HALF_W'(b_bph + b_bpx), 24'b0};
      c_ku   <= b_kl + {b_kh, 24'b0};
      c_fu   <= {b_fu, 16'b0};
      c_ca   <= PH_W'(cfg.c[HALF_W-1:0] * b_uu[HALF_W-1:0]);
      c_cb   <= cb_w[HALF_W-1:0];
      c_cc   <= cc_w[HALF_W-1:0];
      c_up   <= b_up;
      c_act  <= b_act;

      d_cuu  <= c_ca + {HALF_W'(c_cb + c_cc), 24'b0};
      d_base <= c_base;
      d_ku   <= c_ku;
      d_fu   <= c_fu;
      d_up   <= c_up;
      d_act  <= c_act;

      phase   <= d_act ? phi[PH_W-1:PH_W-OUT_W] : '0;
      act_out <= d_act;
    end
  end

endmodule

`default_nettype wire

/* src/fmcw_triangle_chirp_phase_core.sv */
// ----------------------------------------------------------------------------
// fmcw_triangle_chirp_phase_core
// Triangular FMCW chirp phase generator, fully pipelined.
// ----------------------------------------------------------------------------
// Usage:
//   sample_in  : valid/ready channel, one time word (ticks) per transfer.
//   phase_out  : valid/ready channel, one word per input: phase in 2^-32
//                turns and the active flag (phase is 0 when inactive).
//   cfg_*      : write port for leg_ticks, start_freq_word, sweep_curvature
//                and period_limit; write only while no word is in flight.
// Throughput: one word per clock while the receiver keeps up. Pipeline: the
//   restoring divider (an input register plus one quotient bit
//   per stage) followed by the five-stage multiply/add section, the last
//   of which is the output register.
// Stall: the whole pipeline holds while a result waits and the receiver
//   is not ready; nothing is lost or repeated.
// Reset: all valid bits clear, registers return to leg 1, others 0.
// ----------------------------------------------------------------------------
`default_nettype none

module fmcw_triangle_chirp_phase_core import fcp_pkg::*; #(
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  fcp_in_if.sink                 sample_in,
  fcp_out_if.source              phase_out,
  input  wire logic              cfg_wr_en,
  input  wire logic [CFG_AW-1:0] cfg_index,
  input  wire logic [CFG_DW-1:0] cfg_data
);

  localparam int QB = (TIME_BITS < IN_BITS) ? TIME_BITS : IN_BITS;

  cfg_t             cfg;
  logic             adv;
  logic             dv;
  logic [QB-1:0]    dq;
  logic [PER_W-1:0] dr;

  assign adv             = !phase_out.valid || phase_out.ready;
  assign sample_in.ready = adv;

  fcp_cfg u_cfg (
    .clk, .rst, .cfg_wr_en, .cfg_index, .cfg_data, .cfg
  );

  fcp_div #(.QB(QB)) u_div (
    .clk, .rst, .en(adv),
    .in_vld(sample_in.valid),
    .n(sample_in.time_ticks[QB-1:0]),
    .per(cfg.per),
    .out_vld(dv), .q(dq), .r(dr)
  );

  fcp_phase #(.QB(QB)) u_phase (
    .clk, .rst, .en(adv),
    .in_vld(dv), .idx(dq), .loc(dr), .cfg,
    .out_vld(phase_out.valid),
    .phase(phase_out.phase_turns),
    .act_out(phase_out.active)
  );

  a_inactive_zero: assert property (@(posedge clk) disable iff (rst)
    phase_out.valid && !phase_out.active |-> phase_out.phase_turns == '0)
    else $error("inactive word with nonzero phase");

  a_ready_only_on_stall: assert property (@(posedge clk) disable iff (rst)
    !sample_in.ready |-> phase_out.valid && !phase_out.ready)
    else $error("input blocked without an output stall");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> !phase_out.valid)
    else $error("output valid after reset");

endmodule

`default_nettype wire

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Drives time words into the triangular chirp phase core under random idling
// and a long receiver hold-off, predicts each phase word and checks it in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
  import fcp_pkg::*;

  localparam int LATENCY = 40;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct packed {
    logic [OUT_W-1:0] phase;
    logic             active;
  } phase_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_wr_en = 1'b0;
  logic [CFG_AW-1:0] cfg_index = '0;
  logic [CFG_DW-1:0] cfg_data = '0;

  fcp_in_if  sample_in ();
  fcp_out_if phase_out ();

  fmcw_triangle_chirp_phase_core u_dut (
    .clk(clk), .rst(rst), .sample_in(sample_in), .phase_out(phase_out),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  // shadow of the programmed registers
  logic [LEG_W-1:0]  leg_q = 24'd1;
  logic [FREQ_W-1:0] freq_q = '0;
  logic [PH_W-1:0]   curv_q = '0;
  logic [LIM_W-1:0]  limit_q = '0;

  logic [IN_BITS-1:0] pending_times[$];
  phase_word_t        expected_phases[$];
  int errors = 0;
  int hold_off = 0;
  int idle_cycles = 0;

  function automatic phase_word_t chirp_phase(logic [IN_BITS-1:0] n);
    logic [63:0] d, per, idx, loc, f48, c, p, phi, u;
    phase_word_t r;
    d   = (leg_q == 0) ? 64'd1 : 64'(leg_q);
    per = 2 * d;
    idx = 64'(n) / per;
    loc = 64'(n) % per;
    f48 = 64'(freq_q) << 16;
    c   = {{16{curv_q[PH_W-1]}}, curv_q};
    p   = f48 * d + c * d * d;
    phi = 2 * idx * p;
    if (loc < d) begin
      u = loc;
      phi += f48 * u + c * u * u;
    end else begin
      u = loc - d;
      phi += p + (f48 + 2 * c * d) * u - c * u * u;
    end
    r.active = (limit_q == 0) || (idx < 64'(limit_q));
    r.phase  = r.active ? phi[47:16] : '0;
    return r;
  endfunction

  // driver
  int send_gap = 0;
  always @(posedge clk) begin
    if (rst) begin
      sample_in.valid <= 1'b0;
      sample_in.time_ticks <= '0;
    end else if (sample_in.valid && !sample_in.ready) begin
    end else if (sample_in.valid && sample_in.ready) begin
      expected_phases.push_back(chirp_phase(sample_in.time_ticks));
      if (pending_times.size() > 0 && $urandom_range(0, 4) == 0) begin
        sample_in.valid <= 1'b1;
        sample_in.time_ticks <= pending_times.pop_front();
      end else begin
        sample_in.valid <= 1'b0;
        send_gap = $urandom_range(0, 4);
      end
    end else if (send_gap > 0) begin
      send_gap--;
    end else if (pending_times.size() > 0) begin
      sample_in.valid <= 1'b1;
      sample_in.time_ticks <= pending_times.pop_front();
    end
  end

  // monitor and receiver
  int recv_gap = 0;
  always @(posedge clk) begin
    if (rst) begin
      phase_out.ready <= 1'b0;
    end else begin
      if (phase_out.valid && phase_out.ready) begin
        if (expected_phases.size() == 0) begin
          $display("%0t: unexpected word phase=%h active=%b", $time,
                   phase_out.phase_turns, phase_out.active);
          errors++;
        end else begin
          phase_word_t e;
          e = expected_phases.pop_front();
          if (e.phase !== phase_out.phase_turns)
            begin
            $display("%0t: phase_turns expected %h actual %h", $time, e.phase,
                     phase_out.phase_turns);
            errors++;
          end
          if (e.active !== phase_out.active) begin
            $display("%0t: active expected %b actual %b", $time, e.active,
                     phase_out.active);
            errors++;
          end
        end
      end
      if (hold_off > 0) begin
        hold_off--;
        phase_out.ready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        phase_out.ready <= 1'b0;
      end else begin
        phase_out.ready <= 1'b1;
        if (phase_out.valid && phase_out.ready && $urandom_range(0, 2) == 0)
          recv_gap = $urandom_range(0, 4);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((sample_in.valid && sample_in.ready) || (phase_out.valid && phase_out.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic write_reg(logic [CFG_AW-1:0] idx, logic [CFG_DW-1:0] value);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      REG_LEG:   leg_q = value[LEG_W-1:0];
      REG_FREQ:  freq_q = value[FREQ_W-1:0];
      REG_CURV:  curv_q = value[PH_W-1:0];
      default:   limit_q = value[LIM_W-1:0];
    endcase
  endtask

  task automatic drain();
    while (pending_times.size() > 0 || sample_in.valid || expected_phases.size() > 0)
      @(posedge clk);
    repeat (LATENCY) @(posedge clk);
  endtask

  task automatic program_regs(logic [23:0] leg, logic [31:0] freq, logic [47:0] curv,
                              logic [31:0] lim);
    write_reg(REG_LEG, 48'(leg));
    write_reg(REG_FREQ, 48'(freq));
    write_reg(REG_CURV, curv);
    write_reg(REG_LIMIT, 48'(lim));
  endtask

  // mostly times near the active span so the period edges get hit
  function automatic logic [31:0] random_time();
    logic [63:0] span;
    span = 64'((leg_q == 0) ? 1 : leg_q) * 2 * (64'(limit_q) + 2);
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return 32'($urandom_range(0, 64));
      default: return (span > 64'hFFFF_FFFF) ? $urandom() :
                      32'($urandom_range(0, 32'(span)));
    endcase
  endfunction

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // reset config: leg 1, everything zero
    pending_times = '{32'd0, 32'd1, 32'hFFFF_FFFF};
    drain();

    // directed: zero leg length taken as one, extremes, past last period
    program_regs(24'd0, 32'hFFFF_FFFF, 48'h7FFF_FFFF_FFFF, 32'd3);
    pending_times = '{32'd0, 32'd1, 32'd2, 32'd5, 32'd6, 32'd7, 32'hFFFF_FFFF};
    drain();
    program_regs(24'hFF_FFFF, 32'h1234_5678, 48'h8000_0000_0000, 32'hFFFF_FFFF);
    pending_times = '{32'd0, 32'h00FF_FFFE, 32'h00FF_FFFF, 32'h0100_0000,
                      32'h01FF_FFFD, 32'h01FF_FFFE, 32'hFFFF_FFFF, 32'h8000_0000};
    drain();
    program_regs(24'd5, 32'd1000, 48'hFFFF_FFFF_FFF0, 32'd1);
    pending_times = '{32'd0, 32'd4, 32'd5, 32'd9, 32'd10, 32'd11};
    drain();

    // random phases with a receiver hold-off in the first
    for (int ph = 0; ph < 12; ph++) begin
      logic [23:0] leg;
      case ($urandom_range(0, 3))
        0: leg = 24'($urandom_range(1, 8));
        1: leg = 24'($urandom_range(0, 1000));
        2: leg = 24'hFF_FFFF;
        default: leg = 24'($urandom());
      endcase
      program_regs(leg, $urandom(), {16'($urandom()), 32'($urandom())},
                   ($urandom_range(0, 2) == 0) ? 32'd0 : 32'($urandom_range(1, 20)));
      for (int i = 0; i < 120; i++) pending_times.push_back(random_time());
      if (ph == 0) hold_off = 300;
      drain();
    end

    if (errors == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end
endmodule
